@@ rtl/sorted_key_value_table_core_defines.svh @@
// Assertion macros for the sorted key/value table checker.
// Expects clk and rst in the scope where each macro is used.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SKVT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKVT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/skvt_pkg.sv @@
// Shared types, codes and the microcode program of the sorted key/value table.
// No dependencies; imported by the sequencer, datapath, top level and checker.
package skvt_pkg;

  localparam logic [2:0] FN_PUT        = 3'd0;
  localparam logic [2:0] FN_GET        = 3'd1;
  localparam logic [2:0] FN_REMOVE     = 3'd2;
  localparam logic [2:0] FN_ITER_FIRST = 3'd3;
  localparam logic [2:0] FN_ITER_NEXT  = 3'd4;
  localparam logic [2:0] FN_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ITER_END  = 2'd3;

  typedef logic [4:0] step_t;

  localparam step_t S_IDLE = 5'd0;
  localparam step_t S_SRD  = 5'd1;
  localparam step_t S_SCMP = 5'd2;
  localparam step_t S_POST = 5'd3;
  localparam step_t S_PUTW = 5'd4;
  localparam step_t S_FULL = 5'd5;
  localparam step_t S_NF   = 5'd6;
  localparam step_t S_GETV = 5'd7;
  localparam step_t S_INSI = 5'd8;
  localparam step_t S_INSR = 5'd9;
  localparam step_t S_INSW = 5'd10;
  localparam step_t S_DELI = 5'd11;
  localparam step_t S_DELR = 5'd12;
  localparam step_t S_DELW = 5'd13;
  localparam step_t S_ITF  = 5'd14;
  localparam step_t S_ITK  = 5'd15;
  localparam step_t S_ITN  = 5'd16;
  localparam step_t S_ITNK = 5'd17;
  localparam step_t S_CLR  = 5'd18;
  localparam step_t S_FIN  = 5'd19;

  typedef enum logic [4:0] {
    A_NONE, A_LATCH, A_SREAD, A_SCMP, A_PUTW, A_FULL, A_NF, A_GETV,
    A_INSI, A_INSR, A_INSW, A_DELI, A_DELR, A_DELW,
    A_ITF, A_ITK, A_ITN, A_CLR, A_FIN
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT, C_JUMP, C_IDX_END, C_KEY_LT, C_PTR_EQ, C_DEL_END,
    C_CNT_ZERO, C_ITN_END, C_DISPATCH, C_POST, C_WAIT
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic       idx_end;
    logic       key_lt;
    logic       ptr_eq;
    logic       del_end;
    logic       cnt_zero;
    logic       itn_end;
    logic       hit;
    logic       full;
    logic       out_busy;
    logic [2:0] op;
  } flags_t;

  function automatic ctrl_t microcode(input step_t pc);
    ctrl_t w;
    unique case (pc)
      S_IDLE: w = '{act: A_LATCH, cond: C_DISPATCH, target: S_IDLE};
      S_SRD:  w = '{act: A_SREAD, cond: C_IDX_END,  target: S_POST};
      S_SCMP: w = '{act: A_SCMP,  cond: C_KEY_LT,   target: S_SRD};
      S_POST: w = '{act: A_NONE,  cond: C_POST,     target: S_FIN};
      S_PUTW: w = '{act: A_PUTW,  cond: C_JUMP,     target: S_FIN};
      S_FULL: w = '{act: A_FULL,  cond: C_JUMP,     target: S_FIN};
      S_NF:   w = '{act: A_NF,    cond: C_JUMP,     target: S_FIN};
      S_GETV: w = '{act: A_GETV,  cond: C_JUMP,     target: S_FIN};
      S_INSI: w = '{act: A_INSI,  cond: C_NEXT,     target: S_FIN};
      S_INSR: w = '{act: A_INSR,  cond: C_PTR_EQ,   target: S_FIN};
      S_INSW: w = '{act: A_INSW,  cond: C_JUMP,     target: S_INSR};
      S_DELI: w = '{act: A_DELI,  cond: C_NEXT,     target: S_FIN};
      S_DELR: w = '{act: A_DELR,  cond: C_DEL_END,  target: S_FIN};
      S_DELW: w = '{act: A_DELW,  cond: C_JUMP,     target: S_DELR};
      S_ITF:  w = '{act: A_ITF,   cond: C_CNT_ZERO, target: S_FIN};
      S_ITK:  w = '{act: A_ITK,   cond: C_JUMP,     target: S_FIN};
      S_ITN:  w = '{act: A_ITN,   cond: C_ITN_END,  target: S_FIN};
      S_ITNK: w = '{act: A_ITK,   cond: C_JUMP,     target: S_FIN};
      S_CLR:  w = '{act: A_CLR,   cond: C_JUMP,     target: S_FIN};
      S_FIN:  w = '{act: A_FIN,   cond: C_WAIT,     target: S_IDLE};
      default: w = '{act: A_NONE, cond: C_JUMP,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/skvt_seq.sv @@
// Microcode sequencer: step counter, program table lookup and branch logic.
// Depends on skvt_pkg for the program, control word and flag types.
module skvt_seq
  import skvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] func,
  input  flags_t     flags,
  output ctrl_t      ctrl,
  output logic       idle
);

  step_t pc;
  step_t pc_next;
  step_t op_target;
  step_t post_target;

  always_comb begin
    unique case (func) inside
      FN_PUT, FN_GET, FN_REMOVE: op_target = S_SRD;
      FN_ITER_FIRST:             op_target = S_ITF;
      FN_ITER_NEXT:              op_target = S_ITN;
      FN_CLEAR:                  op_target = S_CLR;
      default:                   op_target = S_FIN;
    endcase
  end

  always_comb begin
    unique case (flags.op)
      FN_PUT:  post_target = flags.hit ? S_PUTW : (flags.full ? S_FULL : S_INSI);
      FN_GET:  post_target = flags.hit ? S_GETV : S_NF;
      default: post_target = flags.hit ? S_DELI : S_NF;
    endcase
  end

  always_comb begin
    ctrl    = microcode(pc);
    pc_next = step_t'(pc + 5'd1);
    unique case (ctrl.cond)
      C_NEXT:     ;
      C_JUMP:     pc_next = ctrl.target;
      C_IDX_END:  if (flags.idx_end) pc_next = ctrl.target;
      C_KEY_LT:   if (flags.key_lt) pc_next = ctrl.target;
      C_PTR_EQ:   if (flags.ptr_eq) pc_next = ctrl.target;
      C_DEL_END:  if (flags.del_end) pc_next = ctrl.target;
      C_CNT_ZERO: if (flags.cnt_zero) pc_next = ctrl.target;
      C_ITN_END:  if (flags.itn_end) pc_next = ctrl.target;
      C_DISPATCH: pc_next = accept ? op_target : pc;
      C_POST:     pc_next = post_target;
      C_WAIT:     pc_next = flags.out_busy ? pc : ctrl.target;
      default:    pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign idle = (pc == S_IDLE);

endmodule

@@ rtl/skvt_dp.sv @@
// Datapath: entry memory, scan and shift pointers, count, iterator and result register.
// Depends on skvt_pkg; driven one action per cycle by skvt_seq.
module skvt_dp
  import skvt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  act_t                             act,
  input  logic                             accept,
  input  logic [2:0]                       func,
  input  logic [KEY_BITS-1:0]              key,
  input  logic [VALUE_BITS-1:0]            value,
  input  logic                             order_signed,
  input  logic                             rsp_stall,
  output flags_t                           flags,
  output logic                             rsp_valid,
  output logic [1:0]                       status,
  output logic                             found,
  output logic [VALUE_BITS-1:0]            value_out,
  output logic [KEY_BITS-1:0]              key_out,
  output logic [$clog2(CAPACITY+1)-1:0]    count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;
  localparam logic [KEY_BITS-1:0] KeySign = KEY_BITS'(1'b1) << (KEY_BITS - 1);

  logic [EW-1:0]         mem [CAPACITY];
  logic [EW-1:0]         rdata;
  logic [2:0]            op;
  logic [KEY_BITS-1:0]   k;
  logic [VALUE_BITS-1:0] v;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         ptr;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         ipos;
  logic                  iv;
  logic                  hit;
  logic [1:0]            res_status;
  logic                  res_found;
  logic [VALUE_BITS-1:0] res_vout;
  logic [KEY_BITS-1:0]   res_kout;

  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic [KEY_BITS-1:0]   sign_mask;
  logic                  key_lt;
  logic                  key_eq;
  logic [CW-1:0]         ptr_inc;
  logic [CW-1:0]         ptr_dec;
  logic                  out_busy;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;

  assign rkey      = rdata[EW-1:VALUE_BITS];
  assign rval      = rdata[VALUE_BITS-1:0];
  assign sign_mask = order_signed ? KeySign : '0;
  assign key_lt    = (rkey ^ sign_mask) < (k ^ sign_mask);
  assign key_eq    = (rkey == k);
  assign ptr_inc   = CW'(ptr + 1'b1);
  assign ptr_dec   = CW'(ptr - 1'b1);
  assign out_busy  = rsp_valid && rsp_stall;

  always_comb begin
    flags.idx_end  = (idx >= cnt);
    flags.key_lt   = key_lt;
    flags.ptr_eq   = (ptr == idx);
    flags.del_end  = (ptr_inc >= cnt);
    flags.cnt_zero = (cnt == '0);
    flags.itn_end  = !iv || (ipos >= cnt);
    flags.hit      = hit;
    flags.full     = (cnt == CW'(CAPACITY));
    flags.out_busy = out_busy;
    flags.op       = op;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    we      = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = {k, v};
    unique case (act) inside
      A_SREAD: begin
        rd_en = !flags.idx_end;
      end
      A_PUTW: begin
        we = 1'b1;
      end
      A_INSR: begin
        if (flags.ptr_eq) begin
          we = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec[AW-1:0];
        end
      end
      A_INSW, A_DELW: begin
        we      = 1'b1;
        wr_addr = ptr[AW-1:0];
        wr_data = rdata;
      end
      A_DELR: begin
        rd_en   = !flags.del_end;
        rd_addr = ptr_inc[AW-1:0];
      end
      A_ITF: begin
        rd_en   = !flags.cnt_zero;
        rd_addr = '0;
      end
      A_ITN: begin
        rd_en   = !flags.itn_end;
        rd_addr = ipos[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ipos      <= '0;
      iv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= out_busy || (act == A_FIN);
      unique case (act)
        A_PUTW: begin
          iv <= 1'b0;
        end
        A_INSR: begin
          if (flags.ptr_eq) begin
            cnt <= CW'(cnt + 1'b1);
            iv  <= 1'b0;
          end
        end
        A_DELR: begin
          if (flags.del_end) begin
            cnt <= CW'(cnt - 1'b1);
            iv  <= 1'b0;
          end
        end
        A_ITF: begin
          if (flags.cnt_zero) begin
            ipos <= '0;
            iv   <= 1'b0;
          end else begin
            ipos <= CW'(1);
            iv   <= 1'b1;
          end
        end
        A_ITN: begin
          if (!flags.itn_end) begin
            ipos <= CW'(ipos + 1'b1);
          end
        end
        A_CLR: begin
          cnt  <= '0;
          ipos <= '0;
          iv   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (act)
      A_LATCH: begin
        if (accept) begin
          op         <= func;
          k          <= key;
          v          <= value;
          idx        <= '0;
          hit        <= 1'b0;
          res_status <= ST_OK;
          res_found  <= 1'b0;
          res_vout   <= '0;
          res_kout   <= '0;
        end
      end
      A_SCMP: begin
        if (key_lt) begin
          idx <= CW'(idx + 1'b1);
        end else begin
          hit <= key_eq;
        end
      end
      A_PUTW: res_found  <= 1'b1;
      A_FULL: res_status <= ST_FULL;
      A_NF:   res_status <= ST_NOT_FOUND;
      A_GETV: begin
        res_vout  <= rval;
        res_found <= 1'b1;
      end
      A_INSI: ptr <= cnt;
      A_INSW: ptr <= ptr_dec;
      A_DELI: begin
        res_found <= 1'b1;
        ptr       <= idx;
      end
      A_DELW: ptr <= ptr_inc;
      A_ITF: begin
        if (flags.cnt_zero) begin
          res_status <= ST_ITER_END;
        end
      end
      A_ITK: res_kout <= rkey;
      A_ITN: begin
        if (flags.itn_end) begin
          res_status <= ST_ITER_END;
        end
      end
      A_FIN: begin
        if (!out_busy) begin
          status    <= res_status;
          found     <= res_found;
          value_out <= res_vout;
          key_out   <= res_kout;
          count     <= cnt;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/sorted_key_value_table_core.sv @@
// Sorted key/value table top level: request/response channels, key order register.
// Depends on skvt_pkg, skvt_seq and skvt_dp.
//
// Holds up to CAPACITY key/value pairs in ascending key order in one single-port
// memory, driven by a microcoded sequencer. One request is worked on at a time;
// req_stall is high from acceptance until the result is loaded into the response
// register, and the next request is taken while that response still waits.
// A get, put or remove first scans the stored entries from the start up to the
// position where the search stops; a put that inserts then shifts the entries from
// that position up, and a remove closes the gap. The scan and shift loops move
// entries through the memory's registered read port. A response still held by
// rsp_stall holds the last step until it leaves. The memory needs no clearing
// after reset. Write key_order_signed through the cfg channel only while the block
// is idle.
module sorted_key_value_table_core
  import skvt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [2:0]                    func,
  input  logic [KEY_BITS-1:0]           key,
  input  logic [VALUE_BITS-1:0]         value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [VALUE_BITS-1:0]         value_out,
  output logic [KEY_BITS-1:0]           key_out,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  logic   key_order_signed;
  logic   idle;
  logic   accept;
  ctrl_t  ctrl;
  flags_t flags;

  assign cfg_ready = 1'b1;
  assign req_stall = !idle;
  assign accept    = req_valid && idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_order_signed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      key_order_signed <= cfg_data;
    end
  end

  skvt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .func   (func),
    .flags  (flags),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  skvt_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .act          (ctrl.act),
    .accept       (accept),
    .func         (func),
    .key          (key),
    .value        (value),
    .order_signed (key_order_signed),
    .rsp_stall    (rsp_stall),
    .flags        (flags),
    .rsp_valid    (rsp_valid),
    .status       (status),
    .found        (found),
    .value_out    (value_out),
    .key_out      (key_out),
    .count        (count)
  );

endmodule

@@ rtl/skvt_checker.sv @@
// Port-level checker for the sorted key/value table, bound to the top level.
// Depends on skvt_pkg and sorted_key_value_table_core_defines.svh.
`include "sorted_key_value_table_core_defines.svh"

module skvt_checker
  import skvt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [1:0]                    status,
  input logic                          found,
  input logic [VALUE_BITS-1:0]         value_out,
  input logic [KEY_BITS-1:0]           key_out,
  input logic [$clog2(CAPACITY+1)-1:0] count
);

  `SKVT_ASSERT_IMP(a_full_count, rsp_valid && (status == ST_FULL), count == CAPACITY, "full without full count")
  `SKVT_ASSERT_IMP(a_err_not_found, rsp_valid && (status != ST_OK), !found, "error response flags found")
  `SKVT_ASSERT_IMP(a_key_out_iter, rsp_valid && (key_out != '0), (status == ST_OK) && !found, "key_out outside iterate")
  `SKVT_ASSERT_IMP(a_value_out_get, rsp_valid && (value_out != '0), (status == ST_OK) && found, "value_out without hit")
  `SKVT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(count), "stalled response changed")

endmodule

bind sorted_key_value_table_core skvt_checker #(
  .CAPACITY   (CAPACITY),
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .found     (found),
  .value_out (value_out),
  .key_out   (key_out),
  .count     (count)
);

@@ verif/sorted_key_value_table_core_tb.sv @@
// Self-checking testbench for the sorted key/value table core.
// Runs directed and random operations under both key orders and checks each
// response against an in-bench table model. Depends on skvt_pkg and the RTL.
module sorted_key_value_table_core_tb;
  import skvt_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int KEY_BITS       = 32;
  localparam int VALUE_BITS     = 32;
  localparam int COUNT_BITS     = $clog2(CAPACITY + 1);
  localparam int POOL_SIZE      = 40;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 10;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  localparam logic [KEY_BITS-1:0] KEY_SIGN = {1'b1, {(KEY_BITS - 1){1'b0}}};
  localparam logic [KEY_BITS-1:0] KEY_MAX  = '1;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic [KEY_BITS-1:0]   key_out;
    logic [COUNT_BITS-1:0] count;
  } table_result_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [2:0]            func      = FN_PUT;
  logic [KEY_BITS-1:0]   key       = '0;
  logic [VALUE_BITS-1:0] value     = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [1:0]            status;
  logic                  found;
  logic [VALUE_BITS-1:0] value_out;
  logic [KEY_BITS-1:0]   key_out;
  logic [COUNT_BITS-1:0] count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data  = 1'b0;

  logic [KEY_BITS-1:0]   key_tbl [CAPACITY];
  logic [VALUE_BITS-1:0] val_tbl [CAPACITY];
  logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
  int                    entries;
  int                    iter_pos;
  bit                    iter_ok;
  bit                    signed_order;

  table_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int ops_sent;
  int results_seen;
  int full_rejects;
  int order_writes;
  int fails;
  int quiet_cycles;

  sorted_key_value_table_core #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func     (func),
    .key      (key),
    .value    (value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (status),
    .found    (found),
    .value_out(value_out),
    .key_out  (key_out),
    .count    (count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [KEY_BITS-1:0] ordered(input logic [KEY_BITS-1:0] k);
    return signed_order ? (k ^ KEY_SIGN) : k;
  endfunction

  function automatic int find_slot(input logic [KEY_BITS-1:0] k, output bit hit);
    hit = 1'b0;
    for (int i = 0; i < entries; i++) begin
      if (ordered(key_tbl[i]) >= ordered(k)) begin
        hit = (ordered(key_tbl[i]) == ordered(k));
        return i;
      end
    end
    return entries;
  endfunction

  function automatic table_result_t apply_op(input logic [2:0] op,
                                             input logic [KEY_BITS-1:0] k,
                                             input logic [VALUE_BITS-1:0] v);
    table_result_t r;
    int pos;
    bit hit;
    r = '0;
    case (op)
      FN_PUT: begin
        pos = find_slot(k, hit);
        if (hit) begin
          val_tbl[pos] = v;
          r.found = 1'b1;
          iter_ok = 1'b0;
        end else if (entries >= CAPACITY) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          for (int i = entries; i > pos; i--) begin
            key_tbl[i] = key_tbl[i-1];
            val_tbl[i] = val_tbl[i-1];
          end
          key_tbl[pos] = k;
          val_tbl[pos] = v;
          entries++;
          iter_ok = 1'b0;
        end
      end
      FN_GET: begin
        pos = find_slot(k, hit);
        if (hit) begin
          r.found = 1'b1;
          r.value_out = val_tbl[pos];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      FN_REMOVE: begin
        pos = find_slot(k, hit);
        if (hit) begin
          r.found = 1'b1;
          for (int i = pos; i + 1 < entries; i++) begin
            key_tbl[i] = key_tbl[i+1];
            val_tbl[i] = val_tbl[i+1];
          end
          entries--;
          iter_ok = 1'b0;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      FN_ITER_FIRST: begin
        if (entries == 0) begin
          iter_ok = 1'b0;
          iter_pos = 0;
          r.status = ST_ITER_END;
        end else begin
          r.key_out = key_tbl[0];
          iter_pos = 1;
          iter_ok = 1'b1;
        end
      end
      FN_ITER_NEXT: begin
        if (!iter_ok || iter_pos >= entries) begin
          r.status = ST_ITER_END;
        end else begin
          r.key_out = key_tbl[iter_pos];
          iter_pos++;
        end
      end
      FN_CLEAR: begin
        entries = 0;
        iter_pos = 0;
        iter_ok = 1'b0;
      end
      default: ;
    endcase
    r.count = COUNT_BITS'(entries);
    return r;
  endfunction

  function automatic logic [KEY_BITS-1:0] pool_key();
    if ($urandom_range(0, 3) == 0)
      return $urandom();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0: key_pool[i] = $urandom();
        1: key_pool[i] = KEY_SIGN ^ KEY_BITS'($urandom_range(0, 15));
        2: key_pool[i] = KEY_BITS'($urandom_range(0, 15));
        default: key_pool[i] = KEY_MAX ^ KEY_BITS'($urandom_range(0, 15));
      endcase
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic [KEY_BITS-1:0] k,
                         input logic [VALUE_BITS-1:0] v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    func      <= op;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(apply_op(op, k, v));
    ops_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic write_key_order(input bit make_signed);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= make_signed;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    signed_order = make_signed;
    order_writes++;
  endtask

  task automatic fill_table();
    while (entries < CAPACITY) send_op(FN_PUT, $urandom(), $urandom());
    send_op(FN_PUT, $urandom(), $urandom());
    send_op(FN_PUT, $urandom(), $urandom());
  endtask

  task automatic test_empty_table();
    send_op(FN_GET, '0, '0);
    send_op(FN_REMOVE, KEY_MAX, '0);
    send_op(FN_ITER_FIRST, '0, '0);
    send_op(FN_ITER_NEXT, '0, '0);
    send_op(FN_CLEAR, '0, '0);
  endtask

  task automatic test_basic_ops();
    send_op(FN_PUT, KEY_MAX, '0);
    send_op(FN_PUT, '0, '1);
    send_op(FN_PUT, KEY_SIGN, 32'h5555_5555);
    send_op(FN_PUT, ~KEY_SIGN, 32'hAAAA_AAAA);
    send_op(FN_PUT, KEY_SIGN, 32'h0000_1234);
    send_op(FN_GET, KEY_SIGN, '0);
    send_op(FN_GET, KEY_MAX, '1);
    send_op(FN_GET, 32'h1234_5678, '0);
    send_op(FN_ITER_FIRST, '0, '0);
    repeat (4) send_op(FN_ITER_NEXT, '0, '0);
    send_op(FN_ITER_FIRST, '0, '0);
    send_op(FN_REMOVE, ~KEY_SIGN, '0);
    send_op(FN_ITER_NEXT, '0, '0);
    send_op(FN_REMOVE, '0, '0);
    send_op(FN_REMOVE, KEY_MAX, '0);
    send_op(FN_SPARE_LO, KEY_MAX, '1);
    send_op(FN_SPARE_HI, KEY_MAX, '1);
    send_op(FN_CLEAR, '0, '0);
    send_op(FN_ITER_NEXT, '0, '0);
  endtask

  task automatic test_capacity();
    logic [KEY_BITS-1:0] low_key;
    logic [KEY_BITS-1:0] mid_key;
    logic [KEY_BITS-1:0] top_key;
    send_op(FN_CLEAR, '0, '0);
    fill_table();
    low_key = key_tbl[0];
    mid_key = key_tbl[CAPACITY / 2];
    top_key = key_tbl[CAPACITY - 1];
    send_op(FN_PUT, mid_key, $urandom());
    send_op(FN_GET, mid_key, '0);
    send_op(FN_ITER_FIRST, '0, '0);
    repeat (3) send_op(FN_ITER_NEXT, '0, '0);
    send_op(FN_REMOVE, top_key, '0);
    send_op(FN_PUT, top_key, $urandom());
    send_op(FN_PUT, $urandom(), $urandom());
    send_op(FN_REMOVE, low_key, '0);
    send_op(FN_ITER_FIRST, '0, '0);
    repeat (CAPACITY) send_op(FN_ITER_NEXT, '0, '0);
  endtask

  task automatic test_signed_order();
    send_op(FN_CLEAR, '0, '0);
    send_op(FN_PUT, KEY_SIGN, $urandom());
    send_op(FN_PUT, ~KEY_SIGN, $urandom());
    send_op(FN_PUT, KEY_MAX, $urandom());
    send_op(FN_PUT, '0, $urandom());
    send_op(FN_PUT, KEY_BITS'(1), $urandom());
    send_op(FN_ITER_FIRST, '0, '0);
    repeat (5) send_op(FN_ITER_NEXT, '0, '0);
    send_op(FN_GET, KEY_SIGN, '0);
    send_op(FN_REMOVE, KEY_MAX, '0);
    send_op(FN_GET, ~KEY_SIGN, '0);
  endtask

  task automatic test_order_switch();
    write_key_order(1'b0);
    send_op(FN_GET, '0, '0);
    send_op(FN_GET, KEY_SIGN, '0);
    send_op(FN_PUT, 32'h9000_0000, $urandom());
    send_op(FN_REMOVE, KEY_BITS'(1), '0);
    send_op(FN_ITER_FIRST, '0, '0);
    repeat (5) send_op(FN_ITER_NEXT, '0, '0);
  endtask

  task automatic test_random_ops(input int n_items);
    int target;
    int pick;
    int walk;
    refresh_pool();
    target = ops_sent + n_items;
    while (ops_sent < target) begin
      pick = $urandom_range(0, 199);
      if (pick < 70) begin
        send_op(FN_PUT, pool_key(), $urandom());
      end else if (pick < 110) begin
        send_op(FN_GET, pool_key(), $urandom());
      end else if (pick < 140) begin
        send_op(FN_REMOVE, pool_key(), $urandom());
      end else if (pick < 148) begin
        send_op(FN_ITER_FIRST, $urandom(), $urandom());
        walk = $urandom_range(0, entries + 1);
        repeat (walk) send_op(FN_ITER_NEXT, $urandom(), $urandom());
      end else if (pick < 160) begin
        send_op(FN_ITER_NEXT, $urandom(), $urandom());
      end else if (pick < 166) begin
        send_op(FN_CLEAR, $urandom(), $urandom());
      end else if (pick < 180) begin
        send_op(3'($urandom_range(0, 7)), $urandom(), $urandom());
      end else if (pick < 198) begin
        send_op(FN_PUT, $urandom(), $urandom());
      end else begin
        fill_table();
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          fails++;
        end
        if (value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, value_out);
          fails++;
        end
        if (key_out !== want.key_out) begin
          $error("key_out: expected %h, got %h", want.key_out, key_out);
          fails++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 77;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_basic_ops();
    test_capacity();
    test_random_ops(250);

    set_idling(77, 23);
    write_key_order(1'b1);
    test_signed_order();
    test_order_switch();
    write_key_order(1'b1);
    test_random_ops(250);

    set_idling(0, 0);
    write_key_order(1'b0);
    test_random_ops(100);
    write_key_order(1'b1);
    test_random_ops(100);

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations with %0d responses checked, %0d key order writes.",
             ops_sent, results_seen, order_writes);
    $display("Full-table rejections seen: %0d; %0d field errors.", full_rejects, fails);
    if (fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
